@@ design/ssd_pkg.sv @@
// Shared types and constants for the seven-segment scan driver.
// Holds the action codes, register indexes and the segment table.
// No dependencies.
package ssd_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_MAX_CHAR   = 2'd0,
      CSR_POINT_MASK = 2'd1,
      CSR_BLANK_CODE = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam logic [4:0] MAX_CHAR_RESET   = 5'd31;
   localparam logic [7:0] POINT_MASK_RESET = 8'h7F;
   localparam logic [7:0] BLANK_CODE_RESET = 8'h1D;

   localparam int DIGITS = 8;

   // Active-low segment patterns, decimal point in bit 7.
   function automatic logic [7:0] seg_lookup(input logic [4:0] code);
      logic [7:0] seg;
      unique case (code)
         5'd0:  seg = 8'hC0;
         5'd1:  seg = 8'hF9;
         5'd2:  seg = 8'hA4;
         5'd3:  seg = 8'hB0;
         5'd4:  seg = 8'h99;
         5'd5:  seg = 8'h92;
         5'd6:  seg = 8'h82;
         5'd7:  seg = 8'hF8;
         5'd8:  seg = 8'h80;
         5'd9:  seg = 8'h90;
         5'd10: seg = 8'h88;
         5'd11: seg = 8'h83;
         5'd12: seg = 8'hA7;
         5'd13: seg = 8'hA1;
         5'd14: seg = 8'h86;
         5'd15: seg = 8'h8E;
         5'd16: seg = 8'h89;
         5'd17: seg = 8'h8B;
         5'd18: seg = 8'hC7;
         5'd19: seg = 8'hAB;
         5'd20: seg = 8'hC8;
         5'd21: seg = 8'hA3;
         5'd22: seg = 8'h8C;
         5'd23: seg = 8'h98;
         5'd24: seg = 8'hAF;
         5'd25: seg = 8'h87;
         5'd26: seg = 8'hC1;
         5'd27: seg = 8'h91;
         5'd28: seg = 8'hBF;
         5'd29: seg = 8'hFF;
         5'd30: seg = 8'hFF;
         5'd31: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

@@ design/ssd_decode.sv @@
// Character decoder: clamps a buffer entry and maps it to segments.
// Depends on ssd_pkg for the segment table.
module ssd_decode
   import ssd_pkg::*;
(
   input  logic [7:0] entry,
   input  logic [4:0] max_char,
   input  logic [7:0] point_mask,
   output logic [7:0] segments
);

   logic [7:0] code;
   logic [7:0] seg;

   always_comb begin
      // A clamped entry takes max_char whole, so its decimal point is lost.
      if (entry[6:0] > {2'b00, max_char}) begin
         code = {3'b000, max_char};
      end else begin
         code = entry;
      end
      seg = seg_lookup(code[4:0]);
      if (code[7]) begin
         segments = seg & point_mask;
      end else begin
         segments = seg;
      end
   end

endmodule

@@ design/seven_segment_scan_driver_top.sv @@
// Seven-segment scan driver: one word in, at most one word out per tick.
// A scan tick's result passes the input register, then the result register, before
// it appears on rsp. Throughput: one word per cycle while rsp is not stalled.
// Write and clear words give no result. Synchronous active-high reset sets
// the registers to their defaults, clears the buffer and the scan position.
// Depends on ssd_pkg and ssd_decode.
module seven_segment_scan_driver_top
   import ssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: action[1:0], digit_index[4:2], char_code[12:5], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: common_select[7:0], segments[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [4:0] max_char_ff;
   logic [7:0] point_mask_ff;
   logic [7:0] blank_code_ff;

   logic       in_valid_ff;
   action_type in_action_ff;
   logic [2:0] in_index_ff;
   logic [7:0] in_code_ff;

   logic [7:0] buffer_ff [DIGITS];
   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic [3:0] pos_inc;

   logic       out_valid_ff;
   logic [7:0] out_select_ff;
   logic [7:0] out_seg_ff;

   logic       is_tick;
   logic       out_free;
   logic       advance;
   logic [7:0] seg_in;

   assign is_tick  = in_valid_ff && (in_action_ff == ACT_TICK);
   assign out_free = !out_valid_ff || rsp_tready;
   // Only a tick needs the result slot; writes and clears always retire.
   assign advance  = in_valid_ff && (!is_tick || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      pos_inc = {1'b0, pos_ff} + 4'd1;
      if (pos_inc >= 4'd7) begin
         pos_in = pos_inc[2:0] | 3'd5;
      end else begin
         pos_in = pos_inc[2:0];
      end
   end

   ssd_decode u_decode (
      .entry      (buffer_ff[pos_in]),
      .max_char   (max_char_ff),
      .point_mask (point_mask_ff),
      .segments   (seg_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_char_ff   <= MAX_CHAR_RESET;
         point_mask_ff <= POINT_MASK_RESET;
         blank_code_ff <= BLANK_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_CHAR:   max_char_ff   <= csr_wdata[4:0];
            CSR_POINT_MASK: point_mask_ff <= csr_wdata;
            CSR_BLANK_CODE: blank_code_ff <= csr_wdata;
            CSR_UNUSED:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tdata[1:0]);
         in_index_ff  <= req_tdata[4:2];
         in_code_ff   <= req_tdata[12:5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
         for (int i = 0; i < DIGITS; i++) begin
            buffer_ff[i] <= 8'h00;
         end
      end else if (advance) begin
         unique case (in_action_ff)
            ACT_WRITE: buffer_ff[in_index_ff] <= in_code_ff;
            ACT_TICK:  pos_ff <= pos_in;
            ACT_CLEAR: begin
               for (int i = 0; i < DIGITS; i++) begin
                  buffer_ff[i] <= blank_code_ff;
               end
            end
            ACT_NOP:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && is_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         out_select_ff <= 8'd1 << pos_in;
         out_seg_ff    <= seg_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_seg_ff, out_select_ff};

endmodule
